// ===== rtl/search_text_normalizer_defines.svh =====
// Assertion macros shared by the search text normalizer RTL.
// Used by the modules that carry concurrent checks; no other dependencies.
`ifndef SEARCH_TEXT_NORMALIZER_DEFINES_SVH
`define SEARCH_TEXT_NORMALIZER_DEFINES_SVH
`ifndef SYNTH
// expr must hold at every clock edge outside reset
`define STN_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("stn check failed");
// cond at one edge implies nxt at the following edge
`define STN_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error("stn check failed");
`else
`define STN_ASSERT(lbl, expr)
`define STN_ASSERT_NEXT(lbl, cond, nxt)
`endif
`endif

// ===== rtl/stn_pkg.sv =====
// Shared types, constants and the accent decode table for the text normalizer.
// No dependencies.
`default_nettype none
package stn_pkg;

    localparam logic [1:0] CLS_OTHER  = 2'd0;
    localparam logic [1:0] CLS_LETTER = 2'd1;
    localparam logic [1:0] CLS_DIGIT  = 2'd2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_APOS   = 8'h27;

    // piece slots of one command word, in emission order
    localparam int PIECE_HELD  = 0;
    localparam int PIECE_SPACE = 1;
    localparam int PIECE_MAIN  = 2;
    localparam int NUM_PIECES  = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0]            held_char;
        logic [7:0]            main_char;
        logic [NUM_PIECES-1:0] pieces;
        logic                  text_end;
    } t_cmd;

    // plain letter for an accented Latin-1 byte, zero for anything else
    function automatic logic [7:0] accent_char(input logic [7:0] b);
        logic [7:0] c;
        c = 8'h00;
        if (b[7:6] == 2'b11) begin
            case (b[5:0]) inside
                [6'h00:6'h06], [6'h20:6'h26]: c = 8'h61;
                6'h07, 6'h27:                 c = 8'h63;
                [6'h08:6'h0B], [6'h28:6'h2B]: c = 8'h65;
                [6'h0C:6'h0F], [6'h2C:6'h2F]: c = 8'h69;
                6'h10:                        c = 8'h64;
                6'h11, 6'h31:                 c = 8'h6E;
                [6'h12:6'h16], [6'h32:6'h36],
                6'h18, 6'h38:                 c = 8'h6F;
                [6'h19:6'h1C], [6'h39:6'h3C]: c = 8'h75;
                6'h1D, 6'h3D, 6'h3F:          c = 8'h79;
                default:                      c = 8'h00;
            endcase
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/stn_front.sv =====
// Front end: classifies each input byte, tracks lookahead state, builds command words.
// Depends on stn_pkg.
`default_nettype none
module stn_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_text_end,
    output stn_pkg::t_cmd      o_cmd,
    output logic               o_cmd_push
);

    logic       r_held_valid, n_held_valid;
    logic [7:0] r_held_byte, n_held_byte;
    logic [1:0] r_prior_class, n_prior_class;

    logic       is_ascii, is_letter, is_digit, is_mark, dbl_hyphen;
    logic [7:0] acc;
    logic [7:0] letter_char;
    logic [1:0] pc_eff;
    stn_pkg::t_cmd cmd;

    always_comb begin
        is_ascii = (i_in_byte >= 8'h41 && i_in_byte <= 8'h5A) ||
                   (i_in_byte >= 8'h61 && i_in_byte <= 8'h7A);
        acc         = stn_pkg::accent_char(i_in_byte);
        is_letter   = is_ascii || (acc != 8'h00);
        letter_char = is_ascii ? (i_in_byte | 8'h20) : acc;
        is_digit    = (i_in_byte >= 8'h30 && i_in_byte <= 8'h39);
        is_mark     = (i_in_byte == stn_pkg::CH_HYPHEN) || (i_in_byte == stn_pkg::CH_APOS);
        dbl_hyphen  = r_held_valid && (r_held_byte == stn_pkg::CH_HYPHEN) &&
                      (i_in_byte == stn_pkg::CH_HYPHEN);
        // a resolved held mark leaves the class at other
        pc_eff = r_held_valid ? stn_pkg::CLS_OTHER : r_prior_class;

        cmd.held_char = ((r_prior_class == stn_pkg::CLS_LETTER) && is_letter && !dbl_hyphen)
                        ? r_held_byte : stn_pkg::CH_SPACE;
        cmd.main_char = stn_pkg::CH_SPACE;
        cmd.pieces    = '0;
        cmd.pieces[stn_pkg::PIECE_HELD] = r_held_valid;
        cmd.text_end  = i_text_end;

        n_held_valid  = 1'b0;
        n_held_byte   = r_held_byte;
        n_prior_class = stn_pkg::CLS_OTHER;

        if (dbl_hyphen) begin
            n_prior_class = stn_pkg::CLS_OTHER;
        end else if (is_letter) begin
            cmd.pieces[stn_pkg::PIECE_SPACE] = (pc_eff == stn_pkg::CLS_DIGIT);
            cmd.pieces[stn_pkg::PIECE_MAIN]  = 1'b1;
            cmd.main_char = letter_char;
            n_prior_class = stn_pkg::CLS_LETTER;
        end else if (is_digit) begin
            cmd.pieces[stn_pkg::PIECE_SPACE] = (pc_eff == stn_pkg::CLS_LETTER);
            cmd.pieces[stn_pkg::PIECE_MAIN]  = 1'b1;
            cmd.main_char = i_in_byte;
            n_prior_class = stn_pkg::CLS_DIGIT;
        end else if (is_mark && !i_text_end) begin
            // hold for one byte of lookahead, class of the byte before stays
            n_held_valid  = 1'b1;
            n_held_byte   = i_in_byte;
            n_prior_class = pc_eff;
        end else begin
            cmd.pieces[stn_pkg::PIECE_MAIN] = 1'b1;
            n_prior_class = stn_pkg::CLS_OTHER;
        end

        if (i_text_end) begin
            n_held_valid  = 1'b0;
            n_held_byte   = 8'h00;
            n_prior_class = stn_pkg::CLS_OTHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid  <= 1'b0;
            r_held_byte   <= 8'h00;
            r_prior_class <= stn_pkg::CLS_OTHER;
        end else if (i_accept) begin
            r_held_valid  <= n_held_valid;
            r_held_byte   <= n_held_byte;
            r_prior_class <= n_prior_class;
        end
    end

    assign o_cmd      = cmd;
    assign o_cmd_push = i_accept && (cmd.pieces != '0);

endmodule
`default_nettype wire

// ===== rtl/stn_queue.sv =====
// Short command queue decoupling the front end from the output sequencer.
// Depends on stn_pkg and the assertion macros.
`default_nettype none
`include "search_text_normalizer_defines.svh"
module stn_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire stn_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output stn_pkg::t_cmd      o_head,
    output logic               o_full,
    output logic               o_empty
);

    stn_pkg::t_cmd r_mem [stn_pkg::QUEUE_DEPTH];
    logic [stn_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [stn_pkg::QCNT_W-1:0] r_count;

    assign o_full  = (r_count == stn_pkg::QCNT_W'(stn_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `STN_ASSERT(a_q_no_overflow, !(i_push && o_full))
    `STN_ASSERT(a_q_no_underflow, !(i_pop && o_empty))
    `STN_ASSERT(a_q_ptr_track, r_wr == (r_rd + r_count[stn_pkg::QPTR_W-1:0]))

endmodule
`default_nettype wire

// ===== rtl/stn_back.sv =====
// Back end: walks the pieces of the head command word, one output byte per cycle while the consumer keeps popping.
// Depends on stn_pkg and the assertion macros.
`default_nettype none
`include "search_text_normalizer_defines.svh"
module stn_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire stn_pkg::t_cmd i_head,
    input  wire logic          i_q_empty,
    output logic               o_q_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [7:0]         o_out_byte,
    output logic               o_run_last,
    output logic               o_out_text_end
);

    logic [stn_pkg::NUM_PIECES-1:0] r_done, n_done;
    logic                           r_out_valid;
    logic [7:0]                     r_out_byte;
    logic                           r_run_last, r_out_end;

    logic [stn_pkg::NUM_PIECES-1:0] rem, pick;
    logic                           can_load, load, last;
    logic [7:0]                     sel_byte;

    always_comb begin
        rem  = i_head.pieces & ~r_done;
        pick = '0;
        if (rem[stn_pkg::PIECE_HELD]) begin
            pick[stn_pkg::PIECE_HELD] = 1'b1;
            sel_byte = i_head.held_char;
        end else if (rem[stn_pkg::PIECE_SPACE]) begin
            pick[stn_pkg::PIECE_SPACE] = 1'b1;
            sel_byte = stn_pkg::CH_SPACE;
        end else begin
            pick[stn_pkg::PIECE_MAIN] = 1'b1;
            sel_byte = i_head.main_char;
        end
        last     = ((rem & ~pick) == '0);
        can_load = !r_out_valid || i_pop;
        load     = can_load && !i_q_empty;
        n_done   = last ? '0 : (r_done | pick);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_done <= n_done;
            end
            if (can_load) begin
                r_out_valid <= !i_q_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= sel_byte;
            r_run_last <= last;
            r_out_end  <= last && i_head.text_end;
        end
    end

    assign o_q_pop        = load && last;
    assign o_empty        = !r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_run_last     = r_run_last;
    assign o_out_text_end = r_out_end;

    `STN_ASSERT(a_bk_idle_clear, !i_q_empty || r_done == '0)
    `STN_ASSERT(a_bk_work_left, i_q_empty || rem != '0)
    `STN_ASSERT_NEXT(a_bk_end_is_last, load && last && i_head.text_end,
                     r_run_last && r_out_end)

endmodule
`default_nettype wire

// ===== rtl/search_text_normalizer.sv =====
// Search text normalizer: Latin-1 byte stream in, normalized index text out, one byte a word.
// A byte is accepted every cycle while full is low; a hyphen or apostrophe is held
// for one byte of lookahead. Each input yields zero to two output words, and the
// output side delivers one word per cycle from its output register while pop is high
// or the register is empty. A four-entry command queue between the classifier and
// the output sequencer lets either side stall alone, so new bytes can be taken while
// earlier ones are still queued. An output word passes the queue, then the output register.
// Depends on stn_pkg, stn_front, stn_queue, stn_back.
`default_nettype none
module search_text_normalizer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_text_end,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_out_text_end
);

    stn_pkg::t_cmd cmd, head;
    logic          accept, cmd_push, q_pop, q_full, q_empty;

    assign accept = push && !q_full;
    assign full   = q_full;

    stn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in_byte  (i_in_byte),
        .i_text_end (i_text_end),
        .o_cmd      (cmd),
        .o_cmd_push (cmd_push)
    );

    stn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    stn_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_out_text_end (o_out_text_end)
    );

endmodule
`default_nettype wire
